>>> hw/rtl/amou_pkg.sv
// Package for the atomic memory operation unit: commands, transaction types and FSM states.
package amou_pkg;

  // Operation codes carried in the cmd field
  typedef enum logic [3:0] {
    CMD_LOAD  = 4'd0,
    CMD_STORE = 4'd1,
    CMD_ADD   = 4'd2,
    CMD_SUB   = 4'd3,
    CMD_AND   = 4'd4,
    CMD_OR    = 4'd5,
    CMD_XOR   = 4'd6,
    CMD_XCHG  = 4'd7,
    CMD_CMPXCHG = 4'd8
  } cmd_e;

  // Access size codes (log2 of bytes)
  typedef enum logic [1:0] {
    SIZE_B1 = 2'd0,
    SIZE_B2 = 2'd1,
    SIZE_B4 = 2'd2,
    SIZE_B8 = 2'd3
  } size_e;

  localparam int unsigned ADDR_W = 13;
  localparam int unsigned DATA_W = 64;

  // Request transaction
  typedef struct packed {
    logic [3:0]        cmd;
    logic [1:0]        access_size;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] replacement;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [DATA_W-1:0] old_value;
    logic              fault;
  } rsp_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

endpackage

>>> hw/rtl/amou_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module amou_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/atomic_memory_operation_unit.sv
// Atomic memory operation unit: read-modify-write sequencer around one word RAM.
// The request is registered when accepted; ST_READ reduces the word index and reads the RAM,
// ST_EXEC modifies and writes back the word, and done_o and the result are registered from ST_EXEC.
// busy stays high through ST_READ and ST_EXEC, so a new transaction is taken only once the current one is done.
// The receiver cannot stall; done_o is high for exactly one cycle per result.
// After reset busy stays high while ST_CLEAR writes zero to every RAM word.
module atomic_memory_operation_unit #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  amou_pkg::req_t req_i,
  output logic           done_o,
  output amou_pkg::rsp_t rsp_o
);

  localparam int unsigned AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned IW    = amou_pkg::ADDR_W - 3;         // word index bits
  localparam int unsigned RW    = (AW > IW) ? AW : IW;
  localparam int unsigned K     = 20;                           // reciprocal scale
  localparam int unsigned RECIP = (1 << K) / STORE_WORDS;
  localparam int unsigned PW    = IW + K;
  localparam int unsigned DW    = amou_pkg::DATA_W;

  amou_pkg::state_e state_q, state_d;
  amou_pkg::req_t   req_q;
  logic [PW-1:0]    prod_q, prod_d;
  logic [AW-1:0]    widx_q, widx_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             done_q, done_d;
  amou_pkg::rsp_t   rsp_q, rsp_d;

  logic             accept;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_wdata, ram_rdata;

  logic [DW-1:0]    mask, cur, nxt, opnd, repl, word_new;
  logic [2:0]       align_mask;
  logic [5:0]       shift;
  logic             fault, wr_en;
  logic [IW-1:0]    quot;
  logic [RW-1:0]    rem_raw, rem_fix;

  assign accept = start && !busy;

  // Word index modulo STORE_WORDS: reciprocal estimate, then one correction
  assign prod_d  = PW'(req_i.byte_address[amou_pkg::ADDR_W-1:3]) * PW'(RECIP);
  assign quot    = prod_q[K +: IW];
  assign rem_raw = RW'(req_q.byte_address[amou_pkg::ADDR_W-1:3])
                 - RW'(32'(quot) * 32'(STORE_WORDS));
  assign rem_fix = (32'(rem_raw) >= STORE_WORDS) ? rem_raw - RW'(STORE_WORDS) : rem_raw;
  assign widx_d  = (state_q == amou_pkg::ST_READ) ? AW'(rem_fix) : widx_q;

  // Size mask and alignment check
  always_comb begin
    case (req_q.access_size)
      amou_pkg::SIZE_B1: begin mask = 64'h0000_0000_0000_00FF; align_mask = 3'b000; end
      amou_pkg::SIZE_B2: begin mask = 64'h0000_0000_0000_FFFF; align_mask = 3'b001; end
      amou_pkg::SIZE_B4: begin mask = 64'h0000_0000_FFFF_FFFF; align_mask = 3'b011; end
      default:           begin mask = 64'hFFFF_FFFF_FFFF_FFFF; align_mask = 3'b111; end
    endcase
  end

  assign fault = (req_q.cmd > amou_pkg::CMD_CMPXCHG)
              || ((req_q.byte_address[2:0] & align_mask) != 3'b000);
  assign shift = {req_q.byte_address[2:0], 3'b000};
  assign opnd  = req_q.operand & mask;
  assign repl  = req_q.replacement & mask;
  assign cur   = (ram_rdata >> shift) & mask;

  // Modify step
  always_comb begin
    nxt   = cur;
    wr_en = 1'b1;
    case (req_q.cmd)
      amou_pkg::CMD_LOAD:    wr_en = 1'b0;
      amou_pkg::CMD_STORE:   nxt = opnd;
      amou_pkg::CMD_ADD:     nxt = (cur + opnd) & mask;
      amou_pkg::CMD_SUB:     nxt = (cur - opnd) & mask;
      amou_pkg::CMD_AND:     nxt = cur & opnd;
      amou_pkg::CMD_OR:      nxt = cur | opnd;
      amou_pkg::CMD_XOR:     nxt = cur ^ opnd;
      amou_pkg::CMD_XCHG:    nxt = opnd;
      amou_pkg::CMD_CMPXCHG: begin
        if (cur == opnd) begin
          nxt = repl;
        end else begin
          wr_en = 1'b0;
        end
      end
      default:               wr_en = 1'b0;
    endcase
  end

  assign word_new = (ram_rdata & ~(mask << shift)) | (nxt << shift);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      amou_pkg::ST_CLEAR: begin
        if (clr_q == AW'(STORE_WORDS - 1)) begin
          state_d = amou_pkg::ST_IDLE;
        end
      end
      amou_pkg::ST_IDLE: begin
        if (start) begin
          state_d = amou_pkg::ST_READ;
        end
      end
      amou_pkg::ST_READ:  state_d = amou_pkg::ST_EXEC;
      amou_pkg::ST_EXEC:  state_d = amou_pkg::ST_IDLE;
      default:            state_d = amou_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = widx_q;
    ram_wdata = word_new;
    ram_re    = 1'b0;
    clr_d     = clr_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    case (state_q)
      amou_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
      end
      amou_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      amou_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      amou_pkg::ST_EXEC: begin
        ram_we          = wr_en && !fault;
        done_d          = 1'b1;
        rsp_d.fault     = fault;
        rsp_d.old_value = (fault || req_q.cmd == amou_pkg::CMD_STORE) ? '0 : cur;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amou_pkg::ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i;
      prod_q <= prod_d;
    end
    widx_q <= widx_d;
    rsp_q  <= rsp_d;
  end

  amou_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (widx_d),
    .rdata_o (ram_rdata)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> tb/tb_atomic_memory_operation_unit.sv
// Self-checking testbench for the atomic memory operation unit: queued driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_atomic_memory_operation_unit;
  import amou_pkg::*;

  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned RANDOM_HALF = 875;

  // Command codes outside the defined set
  localparam logic [3:0] CMD_UNDEF_LO = 4'd9;
  localparam logic [3:0] CMD_UNDEF_HI = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done_o;
  rsp_t rsp_o;

  // Pending transactions and the results they should produce
  req_t access_q[$];
  rsp_t want_rsp[$];

  // Shadow copy of the word RAM
  logic [63:0] word_mem [STORE_WORDS];

  logic        req_taken = 1'b0;
  int unsigned burst_left = 5;
  int unsigned gap_left = 0;
  int unsigned fail_count = 0;

  atomic_memory_operation_unit #(
    .STORE_WORDS(STORE_WORDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp);
    fail_count++;
  endtask

  // Carry out one access on the shadow RAM and return its result
  function automatic rsp_t apply_access(input req_t r);
    rsp_t        res;
    logic [63:0] mask, cur, nxt, word, opnd, repl;
    int unsigned nbytes, shift, widx;
    logic        wr;
    res = '0;
    nbytes = 1 << r.access_size;
    mask = (r.access_size == SIZE_B8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
    if (r.cmd > CMD_CMPXCHG || (int'(r.byte_address) & (nbytes - 1)) != 0) begin
      res.fault = 1'b1;
      return res;
    end
    widx = (int'(r.byte_address) >> 3) % STORE_WORDS;
    shift = 8 * int'(r.byte_address[2:0]);
    word = word_mem[widx];
    cur = (word >> shift) & mask;
    opnd = r.operand & mask;
    repl = r.replacement & mask;
    wr = 1'b1;
    case (r.cmd)
      CMD_LOAD: begin
        nxt = cur;
        wr = 1'b0;
      end
      CMD_STORE, CMD_XCHG: nxt = opnd;
      CMD_ADD:  nxt = (cur + opnd) & mask;
      CMD_SUB:  nxt = (cur - opnd) & mask;
      CMD_AND:  nxt = cur & opnd;
      CMD_OR:   nxt = cur | opnd;
      CMD_XOR:  nxt = cur ^ opnd;
      default: begin
        // compare-exchange: write only on a match
        if (cur == opnd) begin
          nxt = repl;
        end else begin
          nxt = cur;
          wr = 1'b0;
        end
      end
    endcase
    if (wr) word_mem[widx] = (word & ~(mask << shift)) | (nxt << shift);
    res.old_value = (r.cmd == CMD_STORE) ? '0 : cur;
    return res;
  endfunction

  function automatic req_t make_access(input logic [3:0] cmd, input size_e sz,
                                       input int unsigned addr, input logic [63:0] opnd,
                                       input logic [63:0] repl);
    req_t r;
    r.cmd = cmd;
    r.access_size = sz;
    r.byte_address = addr[ADDR_W-1:0];
    r.operand = opnd;
    r.replacement = repl;
    return r;
  endfunction

  // Data biased towards values that make compare-exchange hit
  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 3))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 3));
      2:       return '1;
      default: return 64'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_random(input int unsigned n);
    req_t        r;
    int unsigned nbytes, a;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        r.cmd = 4'($urandom_range(int'(CMD_UNDEF_LO), int'(CMD_UNDEF_HI)));
      else
        r.cmd = 4'($urandom_range(int'(CMD_LOAD), int'(CMD_CMPXCHG)));
      r.access_size = 2'($urandom_range(0, 3));
      nbytes = 1 << r.access_size;
      case ($urandom_range(0, 9))
        0:       a = $urandom_range(0, 8191);
        1, 2:    a = $urandom_range(0, 8191) & ~(nbytes - 1);
        3, 4, 5: a = $urandom_range(8160, 8191) & ~(nbytes - 1);
        default: a = $urandom_range(0, 31) & ~(nbytes - 1);
      endcase
      r.byte_address = a[ADDR_W-1:0];
      r.operand = pick_data();
      r.replacement = pick_data();
      access_q.push_back(r);
    end
  endtask

  // Hold off until every queued transaction has been answered
  task automatic wait_drained();
    while (access_q.size() != 0 || start || want_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(negedge clk_i) begin : drive
    logic nxt_start;
    req_t nxt_req;
    nxt_start = start;
    nxt_req = req;
    if (rst_ni) begin
      if (start && req_taken) begin
        nxt_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          case ($urandom_range(0, 3))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 20);
          endcase
        end
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() != 0) begin
          nxt_start = 1'b1;
          nxt_req = access_q.pop_front();
        end
      end
    end
    start <= nxt_start;
    req <= nxt_req;
  end

  // Monitor: check results, then log accepted transactions
  always @(posedge clk_i) begin : watch
    rsp_t exp_r;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (want_rsp.size() == 0) begin
          report_mismatch("result with nothing outstanding", rsp_o.old_value, '0);
        end else begin
          exp_r = want_rsp.pop_front();
          if (rsp_o.old_value !== exp_r.old_value)
            report_mismatch("old_value", rsp_o.old_value, exp_r.old_value);
          if (rsp_o.fault !== exp_r.fault)
            report_mismatch("fault", 64'(rsp_o.fault), 64'(exp_r.fault));
        end
      end
      if (start && !busy) begin
        req_taken = 1'b1;
        want_rsp.push_back(apply_access(req));
      end
    end
  end

  // Stimulus and verdict
  initial begin
    for (int unsigned i = 0; i < STORE_WORDS; i++) word_mem[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every command, wrap, truncation, faults, same-word chains
    access_q.push_back(make_access(CMD_LOAD, SIZE_B8, 0, '0, '0));
    access_q.push_back(make_access(CMD_STORE, SIZE_B8, 8184, '1, '0));
    access_q.push_back(make_access(CMD_LOAD, SIZE_B1, 8191, '0, '1));
    access_q.push_back(make_access(CMD_LOAD, SIZE_B2, 8190, '1, '0));
    access_q.push_back(make_access(CMD_ADD, SIZE_B1, 8191, 64'd1, '0));
    access_q.push_back(make_access(CMD_SUB, SIZE_B1, 0, 64'd1, '0));
    access_q.push_back(make_access(CMD_LOAD, SIZE_B8, 0, '0, '0));
    access_q.push_back(make_access(CMD_STORE, SIZE_B1, 1, 64'hFFFF_FFFF_FFFF_FF5A, '0));
    access_q.push_back(make_access(CMD_STORE, SIZE_B4, 4, 64'hDEAD_BEEF_1234_5678, '0));
    access_q.push_back(make_access(CMD_AND, SIZE_B4, 4, 64'hFFFF_FFFF_0F0F_0F0F, '0));
    access_q.push_back(make_access(CMD_OR, SIZE_B4, 4, 64'h0000_0000_F000_0000, '0));
    access_q.push_back(make_access(CMD_XOR, SIZE_B4, 4, '1, '0));
    access_q.push_back(make_access(CMD_XCHG, SIZE_B2, 2, 64'h5555_0000_0000_ABCD, '0));
    access_q.push_back(make_access(CMD_CMPXCHG, SIZE_B2, 2, 64'hFFFF_0000_0000_ABCD,
                                   64'h0000_0000_0000_1234));
    access_q.push_back(make_access(CMD_CMPXCHG, SIZE_B2, 2, 64'h0000_0000_0000_ABCD,
                                   64'h0000_0000_0000_5555));
    access_q.push_back(make_access(CMD_CMPXCHG, SIZE_B8, 8184, '1, '0));
    access_q.push_back(make_access(CMD_STORE, SIZE_B2, 1, '1, '0));
    access_q.push_back(make_access(CMD_STORE, SIZE_B4, 8190, '1, '0));
    access_q.push_back(make_access(CMD_ADD, SIZE_B8, 8188, '1, '0));
    access_q.push_back(make_access(CMD_UNDEF_LO, SIZE_B1, 0, '1, '1));
    access_q.push_back(make_access(CMD_UNDEF_HI, SIZE_B8, 0, '1, '1));
    access_q.push_back(make_access(CMD_ADD, SIZE_B8, 8, '1, '0));
    access_q.push_back(make_access(CMD_ADD, SIZE_B8, 8, 64'd2, '0));
    access_q.push_back(make_access(CMD_LOAD, SIZE_B8, 8, '0, '0));
    access_q.push_back(make_access(CMD_LOAD, SIZE_B8, 0, '0, '0));
    wait_drained();

    // Random traffic, with a full drain in the middle
    push_random(RANDOM_HALF);
    wait_drained();
    push_random(RANDOM_HALF);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_atomic_memory_operation_unit passed");
    end else begin
      $display("tb_atomic_memory_operation_unit failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("tb_atomic_memory_operation_unit failed");
    $finish;
  end

endmodule
